[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the line solver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define TLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define TLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tls_pkg.sv]
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types, register codes and saturation helpers of the line solver.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int DW = 32;

  localparam logic signed [DW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] Q_MIN = 32'sh8000_0000;

  // configuration register indexes
  localparam logic [1:0] REG_OFF_DIAG  = 2'd0;
  localparam logic [1:0] REG_DIAG_BASE = 2'd1;
  localparam logic [1:0] REG_LINE_LEN  = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_AA,
    S_DG_KICK, S_DG_WAIT, S_DG_WR,
    S_FW_INIT, S_FW_RD, S_FW_KICK, S_FW_WAIT, S_FW_MUL, S_FW_WR,
    S_LS_RD, S_LS_KICK, S_LS_WAIT, S_LS_WR,
    S_BK_RD, S_BK_MUL, S_BK_KICK, S_BK_WAIT, S_BK_WR,
    S_OUT_RD, S_OUT_LD
  } tls_state_t;

  // clamp a 64-bit value into signed 32 bits
  function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DW-1:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = Q_MAX;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = Q_MIN;
    end else begin
      res = v[DW-1:0];
    end
    return res;
  endfunction

endpackage

[hw/rtl/tls_div.sv]
// ----------------------------------------------------------------------------
// tls_div
// Shared signed 64/32 divider, two quotient bits a cycle, truncating,
// result saturated to signed 32 bits; zero divisor saturates by sign.
// ----------------------------------------------------------------------------
module tls_div
  import tls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [63:0]   num,
  input  logic signed [DW-1:0] den,
  output logic                 done,
  output logic signed [DW-1:0] quot
);

  logic          busy_r;
  logic          done_r;
  logic [4:0]    cnt_r;
  logic          neg_r;
  logic          zero_r;
  logic [63:0]   sh_r;     // numerator bits out at the top, quotient bits in
  logic [31:0]   rem_r;
  logic [31:0]   dmag_r;
  logic [63:0]   sh_mid, sh_nxt;
  logic [31:0]   rem_mid, rem_nxt;
  logic [32:0]   t1, t2;
  logic          g1, g2;

  // two restoring steps a cycle
  always_comb begin
    t1      = {rem_r, sh_r[63]};
    g1      = (t1 >= {1'b0, dmag_r});
    rem_mid = g1 ? 32'(t1 - {1'b0, dmag_r}) : t1[31:0];
    sh_mid  = {sh_r[62:0], g1};
    t2      = {rem_mid, sh_mid[63]};
    g2      = (t2 >= {1'b0, dmag_r});
    rem_nxt = g2 ? 32'(t2 - {1'b0, dmag_r}) : t2[31:0];
    sh_nxt  = {sh_mid[62:0], g2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r  <= num[63] ^ den[DW-1];
        zero_r <= (den == '0);
        sh_r   <= num[63] ? 64'(-num) : num;
        dmag_r <= den[DW-1] ? 32'(-den) : den;
        rem_r  <= '0;
        cnt_r  <= '0;
        if (den == '0) begin
          neg_r  <= num[63];
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        sh_r  <= sh_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // saturate the magnitude and apply the sign
  always_comb begin
    if (zero_r) begin
      quot = neg_r ? Q_MIN : Q_MAX;
    end else if (!neg_r) begin
      quot = (sh_r[63:31] != '0) ? Q_MAX : sh_r[31:0];
    end else if ((sh_r[63:32] != '0) || (sh_r[31] && (sh_r[30:0] != '0))) begin
      quot = Q_MIN;
    end else begin
      quot = 32'(-sh_r[31:0]);
    end
  end

  assign done = done_r;

endmodule

[hw/rtl/tridiagonal_line_solver.sv]
// ----------------------------------------------------------------------------
// tridiagonal_line_solver
// Thomas-algorithm solver for one implicit diffusion line, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : register writes (0 off-diagonal a, 1 end diagonal b0,
//            2 line length n, clamped to 2..MAX_LINE). Write only when idle.
//   in_*   : one right-hand-side sample per beat. in_tready stays high
//            between the beats that do not complete the line.
//   out_*  : n solved samples in index order, tlast on the final one.
// The beat completing the line starts the solve; in_tready stays low until
// the last result sits in the output register. All work runs on one 32x32
// multiplier and one shared divider (two bits a cycle). Each line passes
// through the modified-diagonal pass, the forward sweep, the last-element
// divide, the backward sweep and the unload, in that order.
// A stalled receiver holds the output register and halts unloading.
// Reset restores the state, the sample count and the configuration
// (a 0, b0 1.0, n 64) and drops out_tvalid; the other datapath registers
// and the stores need no clearing.
// ----------------------------------------------------------------------------
module tridiagonal_line_solver
  import tls_pkg::*;
#(
  parameter int MAX_LINE = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  // configuration
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  // samples
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // [31:0] density_in
  // results
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,  // [31:0] density_out
  output logic          out_tlast   // last_of_line
);

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int CW = $clog2(MAX_LINE + 1);

  tls_state_t state_r, state_nxt;

  logic signed [DW-1:0] off_r, base_r;
  logic [6:0]           len_r;
  logic [CW-1:0]        cnt_r, n_r, idx_r, n_eff, idx_eff, idx_dec;
  logic signed [DW-1:0] prev_r, cur_d_r, cur_m_r;
  logic signed [63:0]   prod_r;
  logic                 out_valid_r, out_last_r;
  logic [31:0]          out_data_r;

  // stores
  logic signed [DW-1:0] ls_mem [MAX_LINE];
  logic signed [DW-1:0] md_mem [MAX_LINE];
  logic signed [DW-1:0] ls_rd_r, md_rd_r;
  logic                 ls_we, md_we;
  logic [AW-1:0]        ls_waddr, md_waddr, ls_raddr, md_raddr;
  logic signed [DW-1:0] ls_wdata, md_wdata;

  // shared units
  logic                 div_start, div_done;
  logic signed [63:0]   div_num;
  logic signed [DW-1:0] div_den, div_q;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [63:0]   mul_p;

  logic                 in_acc, line_done, out_free, last_pt;
  logic signed [63:0]   dg_val, fw_val, bk_num;

  // check terms
  logic                 div_wait, idx_chk, out_end;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // effective length and load slot
  always_comb begin
    if (len_r < 7'd2) begin
      n_eff = CW'(2);
    end else if (32'(len_r) > MAX_LINE) begin
      n_eff = CW'(MAX_LINE);
    end else begin
      n_eff = CW'(len_r);
    end
    idx_eff   = (32'(cnt_r) >= MAX_LINE) ? CW'(MAX_LINE - 1) : cnt_r;
    line_done = ((idx_eff + CW'(1)) >= n_eff);
    idx_dec   = idx_r - CW'(1);
    last_pt   = (idx_r == n_r - CW'(1));
  end

  // arithmetic of the write-back steps
  always_comb begin
    dg_val = 64'(base_r) - (last_pt ? 64'sd0 : 64'(off_r)) - 64'(div_q);
    fw_val = 64'(cur_d_r) - (prod_r >>> 16);
    bk_num = (64'(cur_d_r) <<< 16) - prod_r;
  end

  // sequencer: next state and strobes
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = prod_r;
    div_den   = prev_r;
    mul_a     = off_r;
    mul_b     = off_r;
    ls_raddr  = idx_r[AW-1:0];
    md_raddr  = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE:    if (in_acc && line_done) state_nxt = S_AA;
      S_AA:      state_nxt = S_DG_KICK;
      S_DG_KICK: begin
        div_start = 1'b1;
        state_nxt = S_DG_WAIT;
      end
      S_DG_WAIT: if (div_done) state_nxt = S_DG_WR;
      S_DG_WR: begin
        ls_raddr  = '0;
        state_nxt = last_pt ? S_FW_INIT : S_DG_KICK;
      end
      S_FW_INIT, S_FW_RD: begin
        md_raddr  = idx_dec[AW-1:0];
        state_nxt = S_FW_KICK;
      end
      S_FW_KICK: begin
        div_start = 1'b1;
        div_num   = {{16{off_r[DW-1]}}, off_r, 16'h0000};
        div_den   = md_rd_r;
        state_nxt = S_FW_WAIT;
      end
      S_FW_WAIT: if (div_done) state_nxt = S_FW_MUL;
      S_FW_MUL: begin
        mul_a     = div_q;
        mul_b     = prev_r;
        state_nxt = S_FW_WR;
      end
      S_FW_WR:   state_nxt = last_pt ? S_LS_RD : S_FW_RD;
      S_LS_RD:   state_nxt = S_LS_KICK;
      S_LS_KICK: begin
        div_start = 1'b1;
        div_num   = {{16{prev_r[DW-1]}}, prev_r, 16'h0000};
        div_den   = md_rd_r;
        state_nxt = S_LS_WAIT;
      end
      S_LS_WAIT: if (div_done) state_nxt = S_LS_WR;
      S_LS_WR:   state_nxt = S_BK_RD;
      S_BK_RD:   state_nxt = S_BK_MUL;
      S_BK_MUL: begin
        mul_b     = prev_r;
        state_nxt = S_BK_KICK;
      end
      S_BK_KICK: begin
        div_start = 1'b1;
        div_num   = bk_num;
        div_den   = cur_m_r;
        state_nxt = S_BK_WAIT;
      end
      S_BK_WAIT: if (div_done) state_nxt = S_BK_WR;
      S_BK_WR:   state_nxt = (idx_r == '0) ? S_OUT_RD : S_BK_RD;
      S_OUT_RD:  state_nxt = S_OUT_LD;
      S_OUT_LD:  if (out_free) state_nxt = last_pt ? S_IDLE : S_OUT_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // store write ports
  always_comb begin
    ls_we    = 1'b0;
    md_we    = 1'b0;
    ls_waddr = idx_r[AW-1:0];
    md_waddr = idx_r[AW-1:0];
    ls_wdata = div_q;
    md_wdata = sat32(dg_val);
    unique case (state_r)
      S_IDLE: begin
        ls_we    = in_acc;
        ls_waddr = idx_eff[AW-1:0];
        ls_wdata = in_tdata;
      end
      S_AA: begin
        md_we    = 1'b1;
        md_waddr = '0;
        md_wdata = base_r;
      end
      S_DG_WR:  md_we = 1'b1;
      S_FW_WR: begin
        ls_we    = 1'b1;
        ls_wdata = sat32(fw_val);
      end
      S_LS_WR, S_BK_WR: ls_we = 1'b1;
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  tls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // stores, registered reads
  always_ff @(posedge clk) begin
    if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
    if (md_we) md_mem[md_waddr] <= md_wdata;
    ls_rd_r <= ls_mem[ls_raddr];
    md_rd_r <= md_mem[md_raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers and load count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      base_r <= 32'sh0001_0000;
      len_r  <= 7'd64;
      cnt_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_OFF_DIAG:  off_r  <= cfg_data;
          REG_DIAG_BASE: base_r <= cfg_data;
          REG_LINE_LEN:  len_r  <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_acc) cnt_r <= line_done ? '0 : idx_eff + CW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        n_r <= n_eff;
      end
      S_AA: begin
        prod_r <= mul_p;
        prev_r <= base_r;
        idx_r  <= CW'(1);
      end
      S_DG_WR: begin
        prev_r <= sat32(dg_val);
        idx_r  <= last_pt ? CW'(1) : idx_r + CW'(1);
      end
      S_FW_INIT: prev_r <= ls_rd_r;
      S_FW_KICK: cur_d_r <= ls_rd_r;
      S_FW_MUL:  prod_r <= mul_p;
      S_FW_WR: begin
        prev_r <= sat32(fw_val);
        if (!last_pt) idx_r <= idx_r + CW'(1);
      end
      S_LS_WR, S_BK_WR: begin
        prev_r <= div_q;
        idx_r  <= (state_r == S_BK_WR && idx_r == '0) ? '0 : idx_dec;
      end
      S_BK_MUL: begin
        prod_r  <= mul_p;
        cur_d_r <= ls_rd_r;
        cur_m_r <= md_rd_r;
      end
      S_OUT_LD: if (out_free && !last_pt) idx_r <= idx_r + CW'(1);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT_LD && out_free) begin
      out_valid_r <= 1'b1;
      out_data_r  <= ls_rd_r;
      out_last_r  <= last_pt;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // terms used by the checks below
  assign div_wait = (state_r == S_DG_WAIT) || (state_r == S_FW_WAIT) ||
                    (state_r == S_LS_WAIT) || (state_r == S_BK_WAIT);
  assign idx_chk  = (state_r == S_FW_WR) || (state_r == S_DG_WR) ||
                    (state_r == S_OUT_LD);
  assign out_end  = out_tvalid && out_tready && out_tlast;

`include "assert_macros.svh"

  `TLS_ASSERT_NOW(a_div_done_in_wait, div_done, div_wait, "divider done outside a wait state")
  `TLS_ASSERT_NXT(a_solve_on_full_line, in_acc && !line_done, state_r == S_IDLE, "early solve")
  `TLS_ASSERT_NOW(a_idx_in_line, idx_chk, idx_r < n_r, "point index beyond the line")
  `TLS_ASSERT_NXT(a_single_last, out_end, !(out_tvalid && out_tlast), "line end repeated")

endmodule

[tb/tridiagonal_line_solver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_line_solver_test
// Self-checking bench for the Thomas-algorithm line solver. Samples stream in
// with random gaps, results drain against random stalls, and every solved
// value is compared with a bit-exact Q16.16 solver kept in the bench. The
// coefficients and the line length are rewritten while idle, also mid-line.
// ----------------------------------------------------------------------------
module tridiagonal_line_solver_test
  import tls_pkg::*;
;

  localparam int          LINE_MAX   = 64;
  localparam logic [1:0]  REG_SPARE  = 2'd3;   // not mapped, write is dropped
  localparam int          SETTLE     = 40;
  localparam longint      CYCLE_CAP  = 2000000;
  localparam longint      S32_MAX    = 64'sd2147483647;
  localparam longint      S32_MIN    = -64'sd2147483648;

  typedef struct {
    logic [31:0] density;
    logic        last;
  } solved_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  tridiagonal_line_solver #(.MAX_LINE(LINE_MAX)) u_dut (.*);

  always #10 clk = ~clk;

  // bench copy of registers and solver state
  longint      coef_a = 0;
  longint      coef_b0 = 65536;
  logic [6:0]  len_reg = 7'd64;
  longint      rhs_store [LINE_MAX];
  longint      diag_store [LINE_MAX];
  int          held_count = 0;

  logic [31:0] sample_q [$];
  solved_t     solved_q [$];
  int          mismatches = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          lines_done = 0;
  longint      cycles = 0;
  bit          no_idle = 1'b0;

  function automatic longint fit_q(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint q_div(longint num, longint den);
    if (den == 0) return (num >= 0) ? S32_MAX : S32_MIN;
    if (num == 64'sh8000_0000_0000_0000 && den == -1) return S32_MAX;
    return fit_q(num / den);
  endfunction

  // run the Thomas algorithm over the held line and queue its results
  function automatic void solve_held(int n);
    longint q;
    longint r;
    longint p;
    diag_store[0] = coef_b0;
    for (int i = 1; i < n; i++) begin
      q = q_div(coef_a * coef_a, diag_store[i-1]);
      diag_store[i] = fit_q(((i != n - 1) ? coef_b0 - coef_a : coef_b0) - q);
    end
    for (int i = 1; i < n; i++) begin
      r = q_div(coef_a * 65536, diag_store[i-1]);
      p = (r * rhs_store[i-1]) >>> 16;
      rhs_store[i] = fit_q(rhs_store[i] - p);
    end
    rhs_store[n-1] = q_div(rhs_store[n-1] * 65536, diag_store[n-1]);
    for (int k = n - 2; k >= 0; k--)
      rhs_store[k] = q_div(rhs_store[k] * 65536 - coef_a * rhs_store[k+1], diag_store[k]);
    for (int k = 0; k < n; k++)
      solved_q.push_back('{density: rhs_store[k][31:0], last: (k == n - 1)});
  endfunction

  function automatic void take_sample(logic [31:0] x);
    int n;
    int idx;
    n = (len_reg < 2) ? 2 : ((len_reg > LINE_MAX) ? LINE_MAX : int'(len_reg));
    idx = (held_count >= LINE_MAX) ? LINE_MAX - 1 : held_count;
    rhs_store[idx] = longint'(signed'(x));
    held_count = idx + 1;
    if (held_count >= n) begin
      solve_held(n);
      held_count = 0;
      lines_done++;
    end
  endfunction

  // sample driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_sample(in_tdata);
        beats_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= sample_q.pop_front();
          in_gap <= no_idle ? 0 : $urandom_range(0, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  int out_stall = 0;
  always @(posedge clk) begin
    solved_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        beats_out++;
        if (solved_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: data %h last %b", out_tdata, out_tlast);
        end else begin
          want = solved_q.pop_front();
          if (out_tdata !== want.density || out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h/%b, got %h/%b",
                       want.density, want.last, out_tdata, out_tlast);
          end
        end
        out_stall <= no_idle ? 0 : $urandom_range(0, 7);
        out_tready <= no_idle;
      end else if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (solved_q.size() == 0 && sample_q.size() == 0 && !in_tvalid);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OFF_DIAG:  coef_a = longint'(signed'(val));
      REG_DIAG_BASE: coef_b0 = longint'(signed'(val));
      REG_LINE_LEN:  len_reg = val[6:0];
      default: ;
    endcase
  endtask

  task automatic queue_line(int count);
    logic [31:0] v;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = 32'h0000_0000;
        3, 4: v = $urandom();
        default: v = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      endcase
      sample_q.push_back(v);
    end
  endtask

  int n_line;
  int long_lines;
  logic [31:0] a_val;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes on the shortest line, a = 0 and b0 = 0 gives zero divisors
    write_reg(REG_OFF_DIAG, 32'h0);
    write_reg(REG_DIAG_BASE, 32'h0);
    write_reg(REG_LINE_LEN, 32'h0);     // below range, acts as 2
    sample_q.push_back(32'h7FFF_FFFF);
    sample_q.push_back(32'h8000_0000);
    sample_q.push_back(32'h0000_0000);
    sample_q.push_back(32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    write_reg(REG_OFF_DIAG, 32'h8000_0000);
    write_reg(REG_DIAG_BASE, 32'h7FFF_FFFF);
    write_reg(REG_LINE_LEN, 32'h1);
    sample_q.push_back(32'h8000_0000);
    sample_q.push_back(32'h8000_0000);
    wait_idle();
    write_reg(REG_OFF_DIAG, 32'hFFFF_C000);   // -0.25
    write_reg(REG_DIAG_BASE, 32'h0001_8000);  // 1.5
    write_reg(REG_LINE_LEN, 32'd6);
    queue_line(6);
    wait_idle();
    // shorten the line with samples held: four held, new length 2
    queue_line(4);
    wait_idle();
    write_reg(REG_LINE_LEN, 32'd2);
    queue_line(1);
    wait_idle();
    // lengthen mid-line: one held, new length 3
    queue_line(1);
    wait_idle();
    write_reg(REG_LINE_LEN, 32'd3);
    queue_line(2);
    wait_idle();

    // random lines, mostly short, up to two at full length early on
    long_lines = 0;
    while (beats_in < 130) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        a_val = $urandom_range(0, 4) == 0 ? $urandom()
              : 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
        write_reg(REG_OFF_DIAG, a_val);
        write_reg(REG_DIAG_BASE, $urandom_range(0, 4) == 0 ? $urandom()
                  : 32'((3 << 16) + $urandom_range(0, 4 << 16)));
      end
      if (long_lines < 2 && beats_in < 60 && $urandom_range(0, 9) == 0) begin
        write_reg(REG_LINE_LEN, long_lines == 0 ? 32'd127 : 32'd64);
        n_line = LINE_MAX;
        long_lines++;
      end else begin
        n_line = $urandom_range(2, 8);
        write_reg(REG_LINE_LEN, {$urandom_range(0, 255) << 7} | n_line);
      end
      queue_line(n_line);
      wait_idle();
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Covered %0d sample beats over %0d solved lines, %0d result beats checked.",
             beats_in, lines_done, beats_out);
    if (mismatches == 0 && solved_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, solved_q.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
